FILE: design/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is high.
`define ORP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ORP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/orp_pkg.sv
// Shared types and codes for the oldest-request panel.
// No dependencies; imported by every module of the block.
package orp_pkg;

  localparam int CFG_W = 5;
  localparam int OP_W  = 2;
  localparam int BTN_W = 4;
  localparam int OLD_W = 4;

  localparam logic [OP_W-1:0] OP_PRESS = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [BTN_W-1:0] button;
  } in_word_t;

  typedef struct packed {
    logic [OLD_W-1:0] oldest_lit;
    logic             any_lit;
    logic             button_lit;
  } out_word_t;

endpackage

FILE: design/orp_age_matrix.sv
// Lit flags, age matrix, their update and the oldest-lit search.
// Depends on orp_pkg.
module orp_age_matrix import orp_pkg::*; #(
  parameter int BUTTONS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  in_word_t         item,
  input  logic [CFG_W-1:0] count,
  output out_word_t        result
);

  localparam int CNT_W = $clog2(BUTTONS + 1);
  localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [BUTTONS-1:0] lit;
  logic [BUTTONS-1:0] lit_next;
  // pressed_before[j][i] set: button j was pressed before button i
  logic [BUTTONS-1:0] pressed_before      [BUTTONS];
  logic [BUTTONS-1:0] pressed_before_next [BUTTONS];

  logic [NW-1:0]      n_raw;
  logic [NW-1:0]      n;
  logic               in_range;
  logic               do_press;
  logic               do_clear;
  logic [BUTTONS-1:0] sel;
  logic [BUTTONS-1:0] present;
  logic [BUTTONS-1:0] lit_p;
  logic [BUTTONS-1:0] older;
  logic [BUTTONS-1:0] cand;
  logic [OLD_W-1:0]   oldest;

  assign n_raw    = NW'(count);
  assign n        = (n_raw > NW'(BUTTONS)) ? NW'(BUTTONS) : n_raw;
  assign in_range = NW'(item.button) < n;
  assign do_press = in_range && (item.opcode == OP_PRESS);
  assign do_clear = in_range && (item.opcode == OP_CLEAR);

  always_comb begin
    for (int j = 0; j < BUTTONS; j++) begin
      sel[j]     = in_range && (NW'(j) == NW'(item.button));
      present[j] = NW'(j) < n;
    end
  end

  always_comb begin
    if (do_press) begin
      lit_next = lit | sel;
    end else if (do_clear) begin
      lit_next = lit & ~sel;
    end else begin
      lit_next = lit;
    end
  end

  // a press makes the button newest: clear its row, set its column elsewhere
  always_comb begin
    for (int j = 0; j < BUTTONS; j++) begin
      if (do_press && sel[j]) begin
        pressed_before_next[j] = '0;
      end else if (do_press) begin
        pressed_before_next[j] = pressed_before[j] | sel;
      end else begin
        pressed_before_next[j] = pressed_before[j];
      end
    end
  end

  assign lit_p = lit_next & present;

  always_comb begin
    for (int i = 0; i < BUTTONS; i++) begin
      older[i] = 1'b0;
      for (int j = 0; j < BUTTONS; j++) begin
        older[i] = older[i] | (lit_p[j] & pressed_before_next[j][i]);
      end
    end
  end

  assign cand = lit_p & ~older;

  // lowest index wins
  always_comb begin
    oldest = '0;
    for (int i = BUTTONS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        oldest = OLD_W'(i);
      end
    end
  end

  assign result.oldest_lit = oldest;
  assign result.any_lit    = |lit_p;
  assign result.button_lit = |(lit_p & sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      lit <= '0;
      for (int j = 0; j < BUTTONS; j++) begin
        pressed_before[j] <= '0;
      end
    end else if (step) begin
      lit <= lit_next;
      for (int j = 0; j < BUTTONS; j++) begin
        pressed_before[j] <= pressed_before_next[j];
      end
    end
  end

endmodule

FILE: design/oldest_request_panel.sv
// Oldest-request panel: a bank of call buttons acted on by index (press,
// clear or query) that reports the lit button pressed longest ago, whether
// any button is lit and whether the addressed button is lit. A word is taken
// into an input register; when the result register can take a result, the
// age-matrix update and the oldest-lit search run as one pass of logic into
// the result register. One word is taken every cycle while the result side
// keeps up. Write buttons_in_use only while the block is idle; buttons at or
// beyond that count are ignored.
// Depends on orp_pkg and orp_age_matrix.
module oldest_request_panel import orp_pkg::*; #(
  parameter int BUTTONS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_wen,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic             hold_valid;
  in_word_t         hold_data;
  logic [CFG_W-1:0] buttons_in_use;
  logic             advance;
  out_word_t        result;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  orp_age_matrix #(
    .BUTTONS (BUTTONS)
  ) u_matrix (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold_data),
    .count  (buttons_in_use),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid     <= 1'b0;
      out_valid      <= 1'b0;
      buttons_in_use <= '0;
    end else begin
      if (in_ready) begin
        hold_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) begin
        buttons_in_use <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_data <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

FILE: design/orp_checker.sv
// Port-level checks for oldest_request_panel, attached by bind.
// Depends on orp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module orp_checker import orp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input in_word_t         in_data,
  input logic             out_valid,
  input logic             out_ready,
  input out_word_t        out_data,
  input logic             cfg_wen,
  input logic [CFG_W-1:0] cfg_wdata
);

  `ORP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")
  `ORP_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result valid right after reset")
  `ORP_ASSERT(a_none_lit, out_valid && !out_data.any_lit |-> out_data.oldest_lit == 4'd0 && !out_data.button_lit, "lit fields set with nothing lit")
  `ORP_ASSERT(a_stall_only, !in_ready |-> out_valid && !out_ready, "input stalled without result back-pressure")

endmodule

bind oldest_request_panel orp_checker u_orp_checker (.*);
